// File: sv/battery_gauge_smoother_assert.svh
// ----------------------------------------------------------------------------
// Battery gauge smoother assertion macros
// Concurrent property wrappers used by the port checker of the gauge.
// ----------------------------------------------------------------------------
`ifndef BATTERY_GAUGE_SMOOTHER_ASSERT_SVH
`define BATTERY_GAUGE_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define BGS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BGS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bgs_pkg.sv
// ----------------------------------------------------------------------------
// Battery gauge smoother package
// Shared widths, codes, register layout and the LiPo discharge curve.
// ----------------------------------------------------------------------------
package bgs_pkg;

  localparam int unsigned RING_DEPTH_DEF = 20;

  localparam int unsigned ADC_W     = 12;
  localparam int unsigned GAIN_W    = 18;
  localparam int unsigned MV_W      = 13;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned PERIODS_W = 10;
  localparam int unsigned ELAPSED_W = 11;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;

  localparam int unsigned MV_MAX      = 8191;
  localparam int unsigned ELAPSED_MAX = 2047;
  localparam int unsigned PCT_FULL    = 100;

  // raw / 5 for raw <= 100 as (raw * 205) >> 10
  localparam int unsigned SNAP_RECIP = 205;
  localparam int unsigned SNAP_SH    = 10;

  localparam int unsigned LUT_LAST = 10;

  localparam logic [GAIN_W-1:0]    RST_MV_PER_COUNT   = GAIN_W'(97089);
  localparam logic [MV_W-1:0]      RST_FULL_LOCK_MV   = MV_W'(4200);
  localparam logic [MV_W-1:0]      RST_LOW_CUTOFF_MV  = MV_W'(3200);
  localparam logic [PERIODS_W-1:0] RST_FULL_LOCK_PER  = PERIODS_W'(180);
  localparam logic [PERIODS_W-1:0] RST_SHUTDOWN_PER   = PERIODS_W'(5);
  localparam logic [PCT_W-1:0]     RST_RISE_MARGIN    = PCT_W'(7);
  localparam logic [PCT_W-1:0]     RST_FALL_MARGIN    = PCT_W'(3);

  typedef enum logic [2:0] {
    REG_MV_PER_COUNT  = 3'd0,
    REG_FULL_LOCK_MV  = 3'd1,
    REG_LOW_CUTOFF_MV = 3'd2,
    REG_FULL_LOCK_PER = 3'd3,
    REG_SHUTDOWN_PER  = 3'd4,
    REG_RISE_MARGIN   = 3'd5,
    REG_FALL_MARGIN   = 3'd6
  } bgs_reg_e;

  typedef enum logic [1:0] {
    STATUS_BATTERY  = 2'd0,
    STATUS_CHARGING = 2'd1,
    STATUS_FULL     = 2'd2
  } charge_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PRIME,
    ST_ACCUM,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_MAP_SEG,
    ST_MAP_INT,
    ST_LOCK,
    ST_UPDATE,
    ST_DONE
  } bgs_state_e;

  typedef struct packed {
    logic [GAIN_W-1:0]    mv_per_count_q16;
    logic [MV_W-1:0]      full_lock_mv;
    logic [MV_W-1:0]      low_cutoff_mv;
    logic [PERIODS_W-1:0] full_lock_periods;
    logic [PERIODS_W-1:0] shutdown_periods;
    logic [PCT_W-1:0]     rise_margin;
    logic [PCT_W-1:0]     fall_margin;
  } bgs_cfg_t;

  function automatic logic [MV_W-1:0] lut_mv(input logic [3:0] idx);
    logic [MV_W-1:0] v;
    unique case (idx)
      4'd0:    v = MV_W'(4150);
      4'd1:    v = MV_W'(4000);
      4'd2:    v = MV_W'(3900);
      4'd3:    v = MV_W'(3800);
      4'd4:    v = MV_W'(3700);
      4'd5:    v = MV_W'(3600);
      4'd6:    v = MV_W'(3500);
      4'd7:    v = MV_W'(3400);
      4'd8:    v = MV_W'(3350);
      4'd9:    v = MV_W'(3300);
      4'd10:   v = MV_W'(3200);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] lut_pct(input logic [3:0] idx);
    logic [PCT_W-1:0] v;
    unique case (idx)
      4'd0:    v = PCT_W'(100);
      4'd1:    v = PCT_W'(90);
      4'd2:    v = PCT_W'(80);
      4'd3:    v = PCT_W'(70);
      4'd4:    v = PCT_W'(60);
      4'd5:    v = PCT_W'(50);
      4'd6:    v = PCT_W'(40);
      4'd7:    v = PCT_W'(30);
      4'd8:    v = PCT_W'(20);
      4'd9:    v = PCT_W'(10);
      default: v = '0;
    endcase
    return v;
  endfunction

  // millivolts per percent step of segment k (segment span / 10)
  function automatic logic [3:0] seg_step(input logic [3:0] k);
    logic [3:0] v;
    unique case (k)
      4'd0:    v = 4'd15;
      4'd7:    v = 4'd5;
      4'd8:    v = 4'd5;
      default: v = 4'd10;
    endcase
    return v;
  endfunction

endpackage

// File: sv/bgs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Battery gauge smoother configuration registers
// APB-style register file holding calibration, thresholds and margins.
// ----------------------------------------------------------------------------
module bgs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgs_pkg::PADDR_W-1:0]   paddr,
  input  logic [bgs_pkg::PDATA_W-1:0]   pwdata,
  output logic [bgs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output bgs_pkg::bgs_cfg_t             cfg_o
);

  bgs_pkg::bgs_cfg_t cfg_q;
  bgs_pkg::bgs_reg_e reg_idx;
  logic              wr_en;

  assign reg_idx = bgs_pkg::bgs_reg_e'(paddr[bgs_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mv_per_count_q16  <= bgs_pkg::RST_MV_PER_COUNT;
      cfg_q.full_lock_mv      <= bgs_pkg::RST_FULL_LOCK_MV;
      cfg_q.low_cutoff_mv     <= bgs_pkg::RST_LOW_CUTOFF_MV;
      cfg_q.full_lock_periods <= bgs_pkg::RST_FULL_LOCK_PER;
      cfg_q.shutdown_periods  <= bgs_pkg::RST_SHUTDOWN_PER;
      cfg_q.rise_margin       <= bgs_pkg::RST_RISE_MARGIN;
      cfg_q.fall_margin       <= bgs_pkg::RST_FALL_MARGIN;
    end else if (wr_en) begin
      unique case (reg_idx)
        bgs_pkg::REG_MV_PER_COUNT:
          cfg_q.mv_per_count_q16 <= pwdata[bgs_pkg::GAIN_W-1:0];
        bgs_pkg::REG_FULL_LOCK_MV:
          cfg_q.full_lock_mv <= pwdata[bgs_pkg::MV_W-1:0];
        bgs_pkg::REG_LOW_CUTOFF_MV:
          cfg_q.low_cutoff_mv <= pwdata[bgs_pkg::MV_W-1:0];
        bgs_pkg::REG_FULL_LOCK_PER:
          cfg_q.full_lock_periods <= pwdata[bgs_pkg::PERIODS_W-1:0];
        bgs_pkg::REG_SHUTDOWN_PER:
          cfg_q.shutdown_periods <= pwdata[bgs_pkg::PERIODS_W-1:0];
        bgs_pkg::REG_RISE_MARGIN:
          cfg_q.rise_margin <= pwdata[bgs_pkg::PCT_W-1:0];
        bgs_pkg::REG_FALL_MARGIN:
          cfg_q.fall_margin <= pwdata[bgs_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bgs_pkg::REG_MV_PER_COUNT:  prdata = bgs_pkg::PDATA_W'(cfg_q.mv_per_count_q16);
      bgs_pkg::REG_FULL_LOCK_MV:  prdata = bgs_pkg::PDATA_W'(cfg_q.full_lock_mv);
      bgs_pkg::REG_LOW_CUTOFF_MV: prdata = bgs_pkg::PDATA_W'(cfg_q.low_cutoff_mv);
      bgs_pkg::REG_FULL_LOCK_PER: prdata = bgs_pkg::PDATA_W'(cfg_q.full_lock_periods);
      bgs_pkg::REG_SHUTDOWN_PER:  prdata = bgs_pkg::PDATA_W'(cfg_q.shutdown_periods);
      bgs_pkg::REG_RISE_MARGIN:   prdata = bgs_pkg::PDATA_W'(cfg_q.rise_margin);
      bgs_pkg::REG_FALL_MARGIN:   prdata = bgs_pkg::PDATA_W'(cfg_q.fall_margin);
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: sv/bgs_ring.sv
// ----------------------------------------------------------------------------
// Battery gauge smoother sample ring
// Single-port-write, registered-read memory holding the millivolt history.
// ----------------------------------------------------------------------------
module bgs_ring #(
  parameter int unsigned DEPTH = bgs_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [bgs_pkg::MV_W-1:0]      wdata_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [bgs_pkg::MV_W-1:0]      rdata_o
);

  logic [bgs_pkg::MV_W-1:0] mem [DEPTH];
  logic [bgs_pkg::MV_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bgs_pct_map.sv
// ----------------------------------------------------------------------------
// Battery gauge smoother percentage map
// Two-stage piecewise-linear lookup from millivolts to raw percent.
// ----------------------------------------------------------------------------
module bgs_pct_map (
  input  logic                       clk_i,
  input  logic [bgs_pkg::MV_W-1:0]   mv_i,
  output logic [bgs_pkg::PCT_W-1:0]  raw_o
);

  logic [3:0]               seg_k;
  logic [bgs_pkg::MV_W-1:0] seg_d;
  logic                     sat_hi_q;
  logic                     sat_lo_q;
  logic [3:0]               seg_k_q;
  logic [7:0]               seg_d_q;
  logic [3:0]               step;
  logic [3:0]               quo;

  // segment index: count of curve points 1 to 10 at or above the input
  always_comb begin
    seg_k = '0;
    for (int j = 1; j <= int'(bgs_pkg::LUT_LAST); j++) begin
      seg_k = seg_k + 4'(bgs_pkg::lut_mv(4'(j)) >= mv_i);
    end
    seg_d = mv_i - bgs_pkg::lut_mv(seg_k + 4'd1);
  end

  always_ff @(posedge clk_i) begin
    sat_hi_q <= mv_i >= bgs_pkg::lut_mv(4'd0);
    sat_lo_q <= mv_i <= bgs_pkg::lut_mv(4'(bgs_pkg::LUT_LAST));
    seg_k_q  <= seg_k;
    seg_d_q  <= seg_d[7:0];
  end

  // interpolate: count whole percent steps covered
  always_comb begin
    step = bgs_pkg::seg_step(seg_k_q);
    quo  = '0;
    for (int j = 1; j <= int'(bgs_pkg::LUT_LAST); j++) begin
      quo = quo + 4'(seg_d_q >= ({4'd0, step} * 8'(j)));
    end
  end

  always_comb begin
    priority if (sat_hi_q) begin
      raw_o = bgs_pkg::PCT_W'(bgs_pkg::PCT_FULL);
    end else if (sat_lo_q) begin
      raw_o = '0;
    end else begin
      raw_o = bgs_pkg::lut_pct(seg_k_q + 4'd1) + bgs_pkg::PCT_W'(quo);
    end
  end

endmodule

// File: sv/battery_gauge_smoother.sv
// ----------------------------------------------------------------------------
// Battery gauge smoother
// Each beat passes the scale, accumulate, divide, map, lock and update states;
// the first beat after reset primes in place of accumulate and divide, and a
// result waits out output stalls. Throughput: one item at a time, set by the
// ring memory read, reciprocal-multiply mean and two-stage curve lookup.
// Reset clears control state and loads register defaults; first beat seeds ring.
// ----------------------------------------------------------------------------
module battery_gauge_smoother #(
  parameter int unsigned RING_DEPTH = bgs_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bgs_pkg::ADC_W-1:0]     adc_sample_i,
  input  logic                          charging_i,
  input  logic                          charge_full_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bgs_pkg::PCT_W-1:0]     percent_o,
  output logic [bgs_pkg::MV_W-1:0]      mean_mv_o,
  output logic [1:0]                    charge_status_o,
  output logic                          shutdown_request_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bgs_pkg::PADDR_W-1:0]   paddr,
  input  logic [bgs_pkg::PDATA_W-1:0]   pwdata,
  output logic [bgs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned POS_W    = $clog2(RING_DEPTH);
  localparam int unsigned TOTAL_W  = $clog2(bgs_pkg::MV_MAX * RING_DEPTH + 1);
  localparam int unsigned PROD_W   = 2 * TOTAL_W;
  localparam int unsigned RECIP_SH = TOTAL_W;
  localparam logic [TOTAL_W-1:0] RECIP   = TOTAL_W'((2 ** RECIP_SH) / RING_DEPTH);
  localparam logic [TOTAL_W-1:0] DEPTH_T = TOTAL_W'(RING_DEPTH);
  localparam logic [POS_W-1:0]   POS_LAST = POS_W'(RING_DEPTH - 1);
  localparam int unsigned SCALE_W  = bgs_pkg::ADC_W + bgs_pkg::GAIN_W;
  localparam int unsigned SNAP_W   = bgs_pkg::PCT_W + 8;
  localparam int unsigned Q5_W     = SNAP_W - bgs_pkg::SNAP_SH;
  localparam logic [bgs_pkg::PCT_W-1:0] PCT_FULL_V = bgs_pkg::PCT_W'(bgs_pkg::PCT_FULL);
  localparam logic [bgs_pkg::ELAPSED_W-1:0] EL_MAX =
    bgs_pkg::ELAPSED_W'(bgs_pkg::ELAPSED_MAX);

  bgs_pkg::bgs_cfg_t   cfg;
  bgs_pkg::bgs_state_e state_q, state_d;

  logic in_accept, ring_we, out_load, out_free;

  // control state
  logic [POS_W-1:0]              pos_q;
  logic                          wrapped_q;
  logic [TOTAL_W-1:0]            total_q;
  logic                          primed_q;
  logic                          full_wait_q, low_wait_q;
  logic [bgs_pkg::ELAPSED_W-1:0] full_el_q, low_el_q;
  logic [bgs_pkg::PCT_W-1:0]     shown_q;
  logic                          out_valid_q;

  // payload
  logic [bgs_pkg::ADC_W-1:0]     adc_q;
  logic                          chg_q, full_q;
  logic [bgs_pkg::MV_W-1:0]      mv_q, prime_mv_q, mean_q;
  logic [PROD_W-1:0]             prod_q;
  logic [bgs_pkg::PCT_W-1:0]     raw_fin_q;
  logic [bgs_pkg::PCT_W-1:0]     res_pct_q, out_pct_q;
  logic [bgs_pkg::MV_W-1:0]      res_mean_q, out_mean_q;
  bgs_pkg::charge_status_e       res_status_q, out_status_q;
  logic                          res_shut_q, out_shut_q;

  // datapath
  logic [SCALE_W-1:0]            scale_prod;
  logic [bgs_pkg::MV_W-1:0]      mv_d;
  logic [bgs_pkg::MV_W-1:0]      ring_rdata, old_mv;
  logic [TOTAL_W-1:0]            total_d, total_prime;
  logic [TOTAL_W-1:0]            q0, q0_times, rem, qc;
  logic [bgs_pkg::MV_W-1:0]      mean_d;
  logic [bgs_pkg::PCT_W-1:0]     map_raw;
  logic                          full_ge, lock;
  logic [bgs_pkg::ELAPSED_W-1:0] full_el_inc, low_el_inc;
  logic [bgs_pkg::PCT_W-1:0]     raw_fin_d;
  logic [SNAP_W-1:0]             snap_prod;
  logic [Q5_W-1:0]               q5;
  logic [bgs_pkg::PCT_W-1:0]     target_snap, target, shown_d;
  logic                          low_cond, shutdown;
  bgs_pkg::charge_status_e       status;

  bgs_cfg_regs u_bgs_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bgs_ring #(
    .DEPTH (RING_DEPTH)
  ) u_bgs_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (pos_q),
    .wdata_i (mv_q),
    .raddr_i (pos_q),
    .rdata_o (ring_rdata)
  );

  bgs_pct_map u_bgs_pct_map (
    .clk_i (clk_i),
    .mv_i  (mean_q),
    .raw_o (map_raw)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bgs_pkg::ST_IDLE:    if (in_valid_i) state_d = bgs_pkg::ST_SCALE;
      bgs_pkg::ST_SCALE:   state_d = primed_q ? bgs_pkg::ST_ACCUM : bgs_pkg::ST_PRIME;
      bgs_pkg::ST_PRIME:   state_d = bgs_pkg::ST_MAP_SEG;
      bgs_pkg::ST_ACCUM:   state_d = bgs_pkg::ST_DIV_MUL;
      bgs_pkg::ST_DIV_MUL: state_d = bgs_pkg::ST_DIV_FIX;
      bgs_pkg::ST_DIV_FIX: state_d = bgs_pkg::ST_MAP_SEG;
      bgs_pkg::ST_MAP_SEG: state_d = bgs_pkg::ST_MAP_INT;
      bgs_pkg::ST_MAP_INT: state_d = bgs_pkg::ST_LOCK;
      bgs_pkg::ST_LOCK:    state_d = bgs_pkg::ST_UPDATE;
      bgs_pkg::ST_UPDATE:  state_d = bgs_pkg::ST_DONE;
      bgs_pkg::ST_DONE:    if (out_free) state_d = bgs_pkg::ST_IDLE;
      default:             state_d = bgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ring_we    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      bgs_pkg::ST_IDLE:  in_stall_o = 1'b0;
      bgs_pkg::ST_ACCUM: ring_we    = 1'b1;
      bgs_pkg::ST_DONE:  out_load   = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  assign scale_prod = SCALE_W'(adc_q) * SCALE_W'(cfg.mv_per_count_q16);
  assign mv_d = (scale_prod[SCALE_W-1:16] > (SCALE_W - 16)'(bgs_pkg::MV_MAX)) ?
                bgs_pkg::MV_W'(bgs_pkg::MV_MAX) : scale_prod[16 +: bgs_pkg::MV_W];

  assign old_mv      = wrapped_q ? ring_rdata : prime_mv_q;
  assign total_d     = total_q - TOTAL_W'(old_mv) + TOTAL_W'(mv_q);
  assign total_prime = TOTAL_W'(mv_q) * DEPTH_T;

  assign q0       = prod_q[PROD_W-1:RECIP_SH];
  assign q0_times = q0 * DEPTH_T;
  assign rem      = total_q - q0_times;
  assign qc       = q0 + TOTAL_W'(rem >= DEPTH_T);
  assign mean_d   = (qc > TOTAL_W'(bgs_pkg::MV_MAX)) ?
                    bgs_pkg::MV_W'(bgs_pkg::MV_MAX) : qc[bgs_pkg::MV_W-1:0];

  assign full_ge     = mean_q >= cfg.full_lock_mv;
  assign full_el_inc = (full_el_q == EL_MAX) ? full_el_q : full_el_q + 1'b1;
  assign lock        = primed_q && full_ge && full_wait_q &&
                       (full_el_inc > bgs_pkg::ELAPSED_W'(cfg.full_lock_periods));
  assign raw_fin_d   = lock ? PCT_FULL_V : map_raw;

  assign snap_prod   = SNAP_W'(raw_fin_q) * SNAP_W'(bgs_pkg::SNAP_RECIP);
  assign q5          = snap_prod[SNAP_W-1:bgs_pkg::SNAP_SH];
  assign target_snap = bgs_pkg::PCT_W'({q5, 2'b00}) + bgs_pkg::PCT_W'(q5);
  assign target      = full_q ? PCT_FULL_V : target_snap;

  always_comb begin
    shown_d = shown_q;
    priority if (!primed_q) begin
      shown_d = target_snap;
    end else if (full_q) begin
      shown_d = PCT_FULL_V;
    end else if (target > shown_q) begin
      if ({1'b0, raw_fin_q} >= {1'b0, shown_q} + {1'b0, cfg.rise_margin}) begin
        shown_d = target;
      end
    end else if (target < shown_q) begin
      if ({1'b0, raw_fin_q} + {1'b0, cfg.fall_margin} <= {1'b0, shown_q}) begin
        shown_d = target;
      end
    end
  end

  assign low_cond   = ((shown_d == '0) || (mean_q <= cfg.low_cutoff_mv)) && !chg_q;
  assign low_el_inc = (low_el_q == EL_MAX) ? low_el_q : low_el_q + 1'b1;
  assign shutdown   = primed_q && low_cond && low_wait_q &&
                      (low_el_inc > bgs_pkg::ELAPSED_W'(cfg.shutdown_periods));
  assign status     = full_q ? bgs_pkg::STATUS_FULL :
                      (chg_q ? bgs_pkg::STATUS_CHARGING : bgs_pkg::STATUS_BATTERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgs_pkg::ST_IDLE;
      pos_q       <= '0;
      wrapped_q   <= 1'b0;
      total_q     <= '0;
      primed_q    <= 1'b0;
      full_wait_q <= 1'b0;
      full_el_q   <= '0;
      low_wait_q  <= 1'b0;
      low_el_q    <= '0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bgs_pkg::ST_PRIME) begin
        total_q <= total_prime;
      end
      if (state_q == bgs_pkg::ST_ACCUM) begin
        total_q <= total_d;
        if (pos_q == POS_LAST) begin
          pos_q     <= '0;
          wrapped_q <= 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (state_q == bgs_pkg::ST_LOCK && primed_q) begin
        full_wait_q <= full_ge;
        full_el_q   <= (full_ge && full_wait_q) ? full_el_inc : '0;
      end
      if (state_q == bgs_pkg::ST_UPDATE) begin
        shown_q  <= shown_d;
        primed_q <= 1'b1;
        if (primed_q) begin
          low_wait_q <= low_cond;
          low_el_q   <= (low_cond && low_wait_q) ? low_el_inc : '0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      adc_q  <= adc_sample_i;
      full_q <= charge_full_i;
      chg_q  <= charging_i && !charge_full_i;
    end
    if (state_q == bgs_pkg::ST_SCALE) begin
      mv_q <= mv_d;
    end
    if (state_q == bgs_pkg::ST_PRIME) begin
      prime_mv_q <= mv_q;
      mean_q     <= mv_q;
    end
    if (state_q == bgs_pkg::ST_DIV_MUL) begin
      prod_q <= PROD_W'(total_q) * PROD_W'(RECIP);
    end
    if (state_q == bgs_pkg::ST_DIV_FIX) begin
      mean_q <= mean_d;
    end
    if (state_q == bgs_pkg::ST_LOCK) begin
      raw_fin_q <= raw_fin_d;
    end
    if (state_q == bgs_pkg::ST_UPDATE) begin
      res_pct_q    <= shown_d;
      res_mean_q   <= mean_q;
      res_status_q <= status;
      res_shut_q   <= shutdown;
    end
    if (out_load) begin
      out_pct_q    <= res_pct_q;
      out_mean_q   <= res_mean_q;
      out_status_q <= res_status_q;
      out_shut_q   <= res_shut_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign percent_o          = out_pct_q;
  assign mean_mv_o          = out_mean_q;
  assign charge_status_o    = out_status_q;
  assign shutdown_request_o = out_shut_q;

endmodule

// File: sv/bgs_checker.sv
// ----------------------------------------------------------------------------
// Battery gauge smoother port checker
// Concurrent checks on the top-level ports, bound to every gauge instance.
// ----------------------------------------------------------------------------
`include "battery_gauge_smoother_assert.svh"

module bgs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [bgs_pkg::PCT_W-1:0]  percent_o,
  input logic [bgs_pkg::MV_W-1:0]   mean_mv_o,
  input logic [1:0]                 charge_status_o,
  input logic                       shutdown_request_o
);

  `BGS_ASSERT_IMP(a_pct_range, clk_i, rst_ni, out_valid_o, percent_o <= 7'd100, "percent above 100")

  `BGS_ASSERT_IMP(a_chg_no_shut, clk_i, rst_ni, out_valid_o && (charge_status_o == bgs_pkg::STATUS_CHARGING), !shutdown_request_o, "shutdown while charging")

  `BGS_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input beat taken while busy")

  `BGS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(percent_o) && $stable(mean_mv_o) && $stable(charge_status_o) && $stable(shutdown_request_o), "stalled output beat changed")

endmodule

bind battery_gauge_smoother bgs_checker u_bgs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .percent_o          (percent_o),
  .mean_mv_o          (mean_mv_o),
  .charge_status_o    (charge_status_o),
  .shutdown_request_o (shutdown_request_o)
);
